// File: rtl/rgb_to_hsv_pixel_converter_top_macros.svh
// Assertion macros for the RGB to HSV converter.
// Used by rgb_to_hsv_pixel_converter_top; no other dependencies.
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rhc: same-cycle check failed");
// next-cycle implication
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rhc: next-cycle check failed");
`else
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every rhc module and the top level.
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned OUT_W      = 15;
    localparam int unsigned DIV_Q_W    = 15;
    localparam int unsigned DIV_NUM_W  = CHAN_W + DIV_Q_W;
    localparam int unsigned DIV_STAGES = DIV_Q_W;

    // pipeline stage indexes
    localparam int unsigned STG_FRONT_A = 0;
    localparam int unsigned STG_FRONT_B = 1;
    localparam int unsigned STG_DIV0    = 2;
    localparam int unsigned NUM_STAGES  = DIV_STAGES + 3;
    localparam int unsigned STG_OUT     = NUM_STAGES - 1;

    localparam int unsigned HUE_SECTOR_UNITS = 3840;
    localparam int unsigned HUE_FULL_UNITS   = 23040;
    localparam int unsigned PERCENT_UNITS    = 25600;
    localparam int unsigned CHANNEL_MAX      = 255;
    localparam int unsigned PCT_PER_CHANNEL  = 100;

    // hue base per sector
    localparam int unsigned HUE_BASE_RED     = 0;
    localparam int unsigned HUE_BASE_RED_NEG = HUE_FULL_UNITS;
    localparam int unsigned HUE_BASE_GREEN   = 2 * HUE_SECTOR_UNITS;
    localparam int unsigned HUE_BASE_BLUE    = 4 * HUE_SECTOR_UNITS;

    // floor(x / 255) estimate: (x * 257) >> 16, here folded into 100 * max
    localparam int unsigned RECIP_SHIFT  = 16;
    localparam int unsigned BRIGHT_RECIP = PCT_PER_CHANNEL * 257;
    localparam int unsigned BRIGHT_Q_W   = 8;
    localparam int unsigned BRIGHT_P_W   = RECIP_SHIFT + BRIGHT_Q_W;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [OUT_W-1:0] brightness;
        logic             achromatic;
    } hsv_t;

    // data riding alongside the dividers
    typedef struct packed {
        logic [OUT_W-1:0]      hue_base;
        logic                  hue_neg;
        logic                  achromatic;
        logic                  max_zero;
        logic [OUT_W-1:0]      bright_x;
        logic [BRIGHT_Q_W-1:0] bright_q;
    } side_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] valid;
    } flow_t;

endpackage

// File: rtl/rgb_to_hsv_pixel_converter_top.sv
// RGB to HSV converter top level: front end, two dividers, output stage.
// Depends on rhc_pkg, rhc_flow, rhc_front, rhc_div and the assertion macro header.
//
//  Channel | Handshake                 | Word
//  --------+---------------------------+--------------------------------------
//  pixel   | pixel_valid / pixel_ready | red, green, blue (8 bits each)
//  hsv     | hsv_valid / hsv_ready     | hue, saturation, brightness, achromatic
//
// One pixel per clock while the output is not stalled by hsv_ready; the result word is registered
// through 18 register stages: 2 front stages, 15 divider stages, output.
// The 15-stage dividers (one quotient bit per stage) set the depth.
// Reset clears only the stage valid bits; data registers are not reset.
// A full stage holds while the stage after it holds; empty stages close up under a stall.
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_converter_top_macros.svh"

module rgb_to_hsv_pixel_converter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pixel_valid,
    output logic            pixel_ready,
    input  rhc_pkg::pixel_t pixel,
    output logic            hsv_valid,
    input  logic            hsv_ready,
    output rhc_pkg::hsv_t   hsv
);
    import rhc_pkg::*;

    flow_t                flow;
    logic [DIV_NUM_W-1:0] hue_num, sat_num;
    logic [CHAN_W-1:0]    hue_den, sat_den;
    side_t                front_side;
    logic [DIV_Q_W-1:0]   hue_quo, sat_quo;
    logic                 hue_rem_nz;
    logic                 sat_rem_nz;
    side_t                side_reg [DIV_STAGES];
    hsv_t                 hsv_next, hsv_reg;

    rhc_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .out_ready (hsv_ready),
        .flow      (flow)
    );

    rhc_front u_front (
        .clk     (clk),
        .en      (flow.en[STG_FRONT_B:STG_FRONT_A]),
        .pix     (pixel),
        .hue_num (hue_num),
        .hue_den (hue_den),
        .sat_num (sat_num),
        .sat_den (sat_den),
        .side    (front_side)
    );

    rhc_div u_hue_div (
        .clk    (clk),
        .en     (flow.en[STG_OUT-1:STG_DIV0]),
        .num    (hue_num),
        .den    (hue_den),
        .quo    (hue_quo),
        .rem_nz (hue_rem_nz)
    );

    // remainder flag unused for saturation (floor only)
    rhc_div u_sat_div (
        .clk    (clk),
        .en     (flow.en[STG_OUT-1:STG_DIV0]),
        .num    (sat_num),
        .den    (sat_den),
        .quo    (sat_quo),
        .rem_nz (sat_rem_nz)
    );

    always_ff @(posedge clk)
    begin
        if (flow.en[STG_DIV0])
        begin
            side_reg[0] <= front_side;
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            if (flow.en[STG_DIV0 + s])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb
    begin
        side_t            sd;
        logic [OUT_W-1:0] hue_ceil;
        logic [OUT_W-1:0] resid;
        logic [OUT_W-1:0] bq;
        sd = side_reg[DIV_STAGES-1];

        // negative side needs ceil of the fraction, taken off the sector base
        hue_ceil = hue_quo + OUT_W'(hue_rem_nz);
        if (sd.achromatic)
        begin
            hsv_next.hue = '0;
        end
        else if (sd.hue_neg)
        begin
            hsv_next.hue = sd.hue_base - hue_ceil;
        end
        else
        begin
            hsv_next.hue = sd.hue_base + hue_quo;
        end

        hsv_next.saturation = (sd.max_zero || sat_rem_nz == 1'b1 && sd.max_zero) ? '0 : sat_quo;

        // brightness = x + floor(x / 255), x = 100 * max; estimate is at most one short
        bq    = OUT_W'(sd.bright_q);
        resid = sd.bright_x - bq * OUT_W'(CHANNEL_MAX);
        if (resid >= OUT_W'(CHANNEL_MAX))
        begin
            bq = bq + OUT_W'(1);
        end
        hsv_next.brightness = sd.bright_x + bq;
        hsv_next.achromatic = sd.achromatic;
    end

    always_ff @(posedge clk)
    begin
        if (flow.en[STG_OUT])
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign pixel_ready = flow.en[STG_FRONT_A];
    assign hsv_valid   = flow.valid[STG_OUT];
    assign hsv         = hsv_reg;

    `RHC_ASSERT_IMP(a_grey_zero, clk, rst_n, hsv_valid && hsv.achromatic, hsv.hue == '0 && hsv.saturation == '0)
    `RHC_ASSERT_IMP(a_out_range, clk, rst_n, hsv_valid, hsv.hue < OUT_W'(HUE_FULL_UNITS) && hsv.saturation <= OUT_W'(PERCENT_UNITS) && hsv.brightness <= OUT_W'(PERCENT_UNITS))
    `RHC_ASSERT_NXT(a_accept_fills, clk, rst_n, pixel_valid && pixel_ready, flow.valid[STG_FRONT_A])

endmodule

// File: rtl/rhc_flow.sv
// Valid/ready control for the converter pipeline: per-stage valid bits and loads.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_flow (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_ready,
    output rhc_pkg::flow_t flow
);
    import rhc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] load;

    // a stage may load when empty or when its successor takes its word
    always_comb
    begin
        load[STG_OUT] = !valid_reg[STG_OUT] || out_ready;
        for (int k = STG_OUT - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign flow.en    = load;
    assign flow.valid = valid_reg;

endmodule

// File: rtl/rhc_front.sv
// Front end: max/min/delta, hue sector, divider numerators and brightness terms.
// Two register stages; depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_front (
    input  logic                          clk,
    input  logic [1:0]                    en,
    input  rhc_pkg::pixel_t               pix,
    output logic [rhc_pkg::DIV_NUM_W-1:0] hue_num,
    output logic [rhc_pkg::CHAN_W-1:0]    hue_den,
    output logic [rhc_pkg::DIV_NUM_W-1:0] sat_num,
    output logic [rhc_pkg::CHAN_W-1:0]    sat_den,
    output rhc_pkg::side_t                side
);
    import rhc_pkg::*;

    // stage A
    logic [CHAN_W-1:0] max_next, min_next, delta_next, diff_next;
    logic [OUT_W-1:0]  base_next;
    logic              neg_next;
    logic [CHAN_W-1:0] max_reg, delta_reg, diff_reg;
    logic [OUT_W-1:0]  base_reg;
    logic              neg_reg;

    // stage B
    logic [DIV_NUM_W-1:0]  hue_num_next, sat_num_next;
    logic [BRIGHT_P_W-1:0] bright_p;
    side_t                 side_next;
    logic [DIV_NUM_W-1:0]  hue_num_reg, sat_num_reg;
    logic [CHAN_W-1:0]     hue_den_reg, sat_den_reg;
    side_t                 side_reg;

    always_comb
    begin
        logic r_top, g_top;
        r_top = (pix.red >= pix.green) && (pix.red >= pix.blue);
        g_top = (pix.green >= pix.blue);

        if (r_top)
        begin
            max_next = pix.red;
        end
        else if (g_top)
        begin
            max_next = pix.green;
        end
        else
        begin
            max_next = pix.blue;
        end

        min_next = pix.red;
        if (pix.green < min_next)
        begin
            min_next = pix.green;
        end
        if (pix.blue < min_next)
        begin
            min_next = pix.blue;
        end
        delta_next = max_next - min_next;

        // ties: red beats green beats blue
        if (r_top)
        begin
            if (pix.green >= pix.blue)
            begin
                base_next = OUT_W'(HUE_BASE_RED);
                neg_next  = 1'b0;
                diff_next = pix.green - pix.blue;
            end
            else
            begin
                base_next = OUT_W'(HUE_BASE_RED_NEG);
                neg_next  = 1'b1;
                diff_next = pix.blue - pix.green;
            end
        end
        else if (g_top)
        begin
            base_next = OUT_W'(HUE_BASE_GREEN);
            neg_next  = (pix.blue < pix.red);
            diff_next = neg_next ? (pix.red - pix.blue) : (pix.blue - pix.red);
        end
        else
        begin
            base_next = OUT_W'(HUE_BASE_BLUE);
            neg_next  = (pix.red < pix.green);
            diff_next = neg_next ? (pix.green - pix.red) : (pix.red - pix.green);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            max_reg   <= max_next;
            delta_reg <= delta_next;
            diff_reg  <= diff_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
        end
    end

    always_comb
    begin
        hue_num_next = DIV_NUM_W'(diff_reg) * DIV_NUM_W'(HUE_SECTOR_UNITS);
        sat_num_next = DIV_NUM_W'(delta_reg) * DIV_NUM_W'(PERCENT_UNITS);
        bright_p     = BRIGHT_P_W'(max_reg) * BRIGHT_P_W'(BRIGHT_RECIP);

        side_next.hue_base   = base_reg;
        side_next.hue_neg    = neg_reg;
        side_next.achromatic = (delta_reg == '0);
        side_next.max_zero   = (max_reg == '0);
        side_next.bright_x   = OUT_W'(max_reg) * OUT_W'(PCT_PER_CHANNEL);
        // may be one short; fixed in the output stage
        side_next.bright_q   = bright_p[BRIGHT_P_W-1 -: BRIGHT_Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= delta_reg;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= max_reg;
            side_reg    <= side_next;
        end
    end

    assign hue_num = hue_num_reg;
    assign hue_den = hue_den_reg;
    assign sat_num = sat_num_reg;
    assign sat_den = sat_den_reg;
    assign side    = side_reg;

endmodule

// File: rtl/rhc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit DIV_Q_W bits; depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div (
    input  logic                           clk,
    input  logic [rhc_pkg::DIV_STAGES-1:0] en,
    input  logic [rhc_pkg::DIV_NUM_W-1:0]  num,
    input  logic [rhc_pkg::CHAN_W-1:0]     den,
    output logic [rhc_pkg::DIV_Q_W-1:0]    quo,
    output logic                           rem_nz
);
    import rhc_pkg::*;

    logic [CHAN_W-1:0]  rem_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0] low_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0] quo_reg [DIV_STAGES];
    logic [CHAN_W-1:0]  den_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [CHAN_W-1:0]  rem_in, den_in, rem_next;
            logic [DIV_Q_W-1:0] low_in, quo_in, low_next, quo_next;
            logic [CHAN_W:0]    trial;
            logic               fits;

            if (s == 0)
            begin : g_first
                // top bits start as the partial remainder (below den when quotient fits)
                assign rem_in = num[DIV_NUM_W-1 -: CHAN_W];
                assign low_in = num[DIV_Q_W-1:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            always_comb
            begin
                trial    = {rem_in, low_in[DIV_Q_W-1]};
                fits     = (trial >= {1'b0, den_in});
                rem_next = fits ? CHAN_W'(trial - {1'b0, den_in}) : trial[CHAN_W-1:0];
                low_next = {low_in[DIV_Q_W-2:0], 1'b0};
                quo_next = {quo_in[DIV_Q_W-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    low_reg[s] <= low_next;
                    quo_reg[s] <= quo_next;
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo    = quo_reg[DIV_STAGES-1];
    assign rem_nz = (rem_reg[DIV_STAGES-1] != '0);

endmodule
